// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the raw profile hex decoder.
// Expects signals clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define RPHD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rphd assertion failed");

// Next-cycle implication, off while reset is low.
`define RPHD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rphd assertion failed");

`endif

// ===== rtl/core/rphd_pkg.sv =====
// Package of the raw profile hex decoder: payload types, status codes,
// character constants and the default size cap. No dependencies.
package rphd_pkg;

  localparam int unsigned MAX_PROFILE_BYTES_DEF = 65536;

  localparam int unsigned COUNT_RADIX  = 10;
  localparam int unsigned NIBBLE_RADIX = 16;

  // Status codes of a result transaction
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_HEADER = 2'd1;
  localparam logic [1:0] ST_DATA   = 2'd2;

  // ASCII characters the decoder looks for
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A_LC  = 8'h61;
  localparam logic [7:0] CH_F_LC  = 8'h66;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } rphd_in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] status;
    logic       last_of_profile;
  } rphd_out_t;

endpackage

// ===== rtl/core/rphd_stream_if.sv =====
// Valid/ready stream interface used by both channels of the decoder.
// Payload type is set per instance; no package dependency.
interface rphd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/raw_profile_hex_decoder.sv =====
// Channel   Dir  Payload                                   Transaction when
// in_chan   in   text_byte[7:0], end_of_text               valid && ready
// out_chan  out  data_byte[7:0], status[1:0], last_of_prof  valid && ready
//
// One text byte is taken per cycle unless stalled; each byte is decoded in
// the cycle it is accepted and its result (if any) lands in the output
// register at that same edge, so the sink sees it from the next cycle on.
// Throughput is one byte per clock, set by the single output register stage.
// in_chan.ready is low only while the output register holds a result the sink
// has not taken; a result taken in the same cycle frees the slot at once.
// Synchronous active-low reset returns to the skip-first-byte phase, empty.
//
// Raw profile hex text decoder: top level. Depends on rphd_pkg,
// rphd_stream_if and assert_macros.svh.
`include "assert_macros.svh"

module raw_profile_hex_decoder #(
  parameter int unsigned MAX_PROFILE_BYTES = rphd_pkg::MAX_PROFILE_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  rphd_stream_if.sink   in_chan,
  rphd_stream_if.source out_chan
);
  import rphd_pkg::*;

  // Count width holds the cap plus one (saturation value)
  localparam int unsigned LEN_W = $clog2(MAX_PROFILE_BYTES + 2);
  // Room for ten times the count plus one digit
  localparam int unsigned ACC_W = LEN_W + 4;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PROFILE_BYTES);
  localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(MAX_PROFILE_BYTES + 1);
  localparam logic [ACC_W-1:0] ACC_MAX = ACC_W'(MAX_PROFILE_BYTES);

  typedef enum logic [5:0] {
    PH_SKIP_FIRST = 6'b000001,
    PH_SEEK_NL    = 6'b000010,
    PH_BLANKS     = 6'b000100,
    PH_DIGITS     = 6'b001000,
    PH_DATA       = 6'b010000,
    PH_DONE       = 6'b100000
  } phase_t;

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  phase_t           phase_r, phase_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;       // declared byte count
  logic [LEN_W-1:0] rem_r, rem_nxt;       // bytes still to decode
  logic [3:0]       hi_nib_r, hi_nib_nxt;
  logic             nib_pend_r, nib_pend_nxt;

  logic             out_valid_r;
  rphd_out_t        out_data_r;

  // Result of the byte being accepted
  logic             res_vld;
  rphd_out_t        res;

  // ---------------------------------------------------------------------
  // Handshake: accept whenever the output slot is empty or being drained
  // ---------------------------------------------------------------------
  logic in_fire;
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_data_r;

  // ---------------------------------------------------------------------
  // Character classes and arithmetic on the incoming byte
  // ---------------------------------------------------------------------
  logic [7:0]       c;
  logic             eot;
  logic             is_dec, is_hex, is_blank;
  logic [3:0]       nib_val;
  logic [ACC_W-1:0] acc;
  logic [LEN_W-1:0] len_acc;
  logic [LEN_W-1:0] rem_dec;
  logic [7:0]       pair_byte;

  assign c        = in_chan.payload.text_byte;
  assign eot      = in_chan.payload.end_of_text;
  assign is_dec   = (c >= CH_0) && (c <= CH_9);
  assign is_hex   = is_dec || ((c >= CH_A_LC) && (c <= CH_F_LC));
  assign is_blank = (c == CH_NUL) || (c == CH_SPACE) || (c == CH_NL);
  // '0'..'9' map by low nibble; 'a'..'f' have low nibble 1..6, add 9
  assign nib_val  = is_dec ? c[3:0] : (c[3:0] + 4'd9);

  // Count times ten plus the new digit, saturating one above the cap
  assign acc       = (ACC_W'(len_r) << 3) + (ACC_W'(len_r) << 1) + ACC_W'(c[3:0]);
  assign len_acc   = (acc > ACC_MAX) ? LEN_SAT : acc[LEN_W-1:0];
  assign rem_dec   = (rem_r == '0) ? '0 : (rem_r - LEN_W'(1));
  assign pair_byte = {hi_nib_r, nib_val};

  // ---------------------------------------------------------------------
  // Decode step
  // ---------------------------------------------------------------------
  always_comb begin
    phase_nxt    = phase_r;
    len_nxt      = len_r;
    rem_nxt      = rem_r;
    hi_nib_nxt   = hi_nib_r;
    nib_pend_nxt = nib_pend_r;
    res_vld      = 1'b0;
    res          = '{data_byte: 8'h00, status: ST_OK, last_of_profile: 1'b0};

    if (in_fire) begin
      if (phase_r == PH_DONE) begin
        // Drop bytes until the end flag, then rearm
        if (eot) begin
          phase_nxt = PH_SKIP_FIRST;
        end
      end else if (phase_r != PH_DATA) begin
        if (eot) begin
          // Text ended inside the header
          res_vld    = 1'b1;
          res.status = ST_HEADER;
          phase_nxt  = PH_SKIP_FIRST;
        end else begin
          unique case (phase_r)
            PH_SKIP_FIRST: begin
              phase_nxt = PH_SEEK_NL;
            end
            PH_SEEK_NL: begin
              if (c == CH_NL) begin
                phase_nxt = PH_BLANKS;
              end
            end
            PH_BLANKS, PH_DIGITS: begin
              if ((phase_r == PH_BLANKS) && is_blank) begin
                phase_nxt = PH_BLANKS;
              end else if (is_dec) begin
                phase_nxt = PH_DIGITS;
                len_nxt   = len_acc;
              end else if ((len_r == '0) || (len_r > LEN_MAX)) begin
                // Bad count: flag on the character after the digits
                res_vld    = 1'b1;
                res.status = ST_HEADER;
                phase_nxt  = PH_DONE;
              end else begin
                rem_nxt      = len_r;
                nib_pend_nxt = 1'b0;
                hi_nib_nxt   = 4'h0;
                phase_nxt    = PH_DATA;
              end
            end
            default: begin
              res_vld    = 1'b1;
              res.status = ST_HEADER;
              phase_nxt  = PH_DONE;
            end
          endcase
        end
      end else begin
        // Hex data
        priority if (eot && !nib_pend_r && (rem_r == len_r)) begin
          // Header with no data at all
          res_vld    = 1'b1;
          res.status = ST_HEADER;
          phase_nxt  = PH_SKIP_FIRST;
        end else if (!is_hex) begin
          if ((c == CH_NUL) || eot) begin
            res_vld    = 1'b1;
            res.status = ST_DATA;
            phase_nxt  = eot ? PH_SKIP_FIRST : PH_DONE;
          end
        end else if (!nib_pend_r) begin
          hi_nib_nxt   = nib_val;
          nib_pend_nxt = 1'b1;
          if (eot) begin
            res_vld    = 1'b1;
            res.status = ST_DATA;
            phase_nxt  = PH_SKIP_FIRST;
          end
        end else begin
          nib_pend_nxt = 1'b0;
          rem_nxt      = rem_dec;
          res_vld      = 1'b1;
          if (rem_dec == '0) begin
            res.data_byte       = pair_byte;
            res.last_of_profile = 1'b1;
            phase_nxt           = eot ? PH_SKIP_FIRST : PH_DONE;
          end else if (eot) begin
            // Digits missing: report instead of the completed byte
            res.status = ST_DATA;
            phase_nxt  = PH_SKIP_FIRST;
          end else begin
            res.data_byte = pair_byte;
          end
        end
      end

      // Rearm clears the counters and the nibble holder
      if ((phase_nxt == PH_SKIP_FIRST) && (phase_r != PH_SKIP_FIRST)) begin
        len_nxt      = '0;
        rem_nxt      = '0;
        hi_nib_nxt   = 4'h0;
        nib_pend_nxt = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SKIP_FIRST;
      len_r       <= '0;
      rem_r       <= '0;
      hi_nib_r    <= 4'h0;
      nib_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      len_r      <= len_nxt;
      rem_r      <= rem_nxt;
      hi_nib_r   <= hi_nib_nxt;
      nib_pend_r <= nib_pend_nxt;
      if (in_fire) begin
        out_valid_r <= res_vld;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: load on every accepted byte that yields a result
  always_ff @(posedge clk) begin
    if (in_fire && res_vld) begin
      out_data_r <= res;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `RPHD_ASSERT_IMP(a_err_clean, out_valid_r && (out_data_r.status != ST_OK),
                   (out_data_r.data_byte == 8'h00) && !out_data_r.last_of_profile)
  `RPHD_ASSERT_IMP(a_data_count, phase_r == PH_DATA,
                   (rem_r != '0) && (rem_r <= len_r) && (len_r != '0) && (len_r <= LEN_MAX))
  `RPHD_ASSERT_IMP(a_len_sat, 1'b1, len_r <= LEN_SAT)
  `RPHD_ASSERT_NXT(a_last_ends, in_fire && res_vld && res.last_of_profile,
                   (phase_r == PH_DONE) || (phase_r == PH_SKIP_FIRST))

endmodule
